### hw/rtl/actf_pkg.sv
// shared constants, tables and types for the astigmatic ctf evaluator
package actf_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int XY_W         = 34;
    localparam int Z_W          = 33;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    localparam longint PI_Q28     = 64'sd843314857;
    localparam longint CNT_DIV    = 2 * PI_Q28;
    localparam longint CNT_RECIP  = (64'sd1 <<< 54) / CNT_DIV;
    localparam logic [29:0] INV2PI_Q16 = 30'd683565276;

    // pipeline stage indexes, one valid bit each
    localparam int ST_A    = CORDIC_LAT;
    localparam int ST_B    = ST_A + 1;
    localparam int ST_C    = ST_A + 2;
    localparam int ST_D    = ST_A + 3;
    localparam int ST_E    = ST_A + 4;
    localparam int ST_F    = ST_A + 5;
    localparam int ST_G    = ST_A + 6;
    localparam int ST_C2   = ST_G + 1;
    localparam int ST_H    = ST_G + 1;
    localparam int ST_I    = ST_G + 2;
    localparam int CNT_DLY = CORDIC_LAT - 2;
    localparam int ST_OUT  = ST_C2 + CORDIC_LAT;
    localparam int NST     = ST_OUT + 1;

    typedef enum logic [2:0] {
        REG_DMIN,
        REG_DMAX,
        REG_AST,
        REG_SCALE,
        REG_COEFF,
        REG_AMP,
        REG_EXTRA
    } t_cfg_reg;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic signed [Z_W-1:0] atan_turn(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 33'sd536870912;
            1:  v = 33'sd316933406;
            2:  v = 33'sd167458907;
            3:  v = 33'sd85004756;
            4:  v = 33'sd42667331;
            5:  v = 33'sd21354465;
            6:  v = 33'sd10679838;
            7:  v = 33'sd5340245;
            8:  v = 33'sd2670163;
            9:  v = 33'sd1335087;
            10: v = 33'sd667544;
            11: v = 33'sd333772;
            12: v = 33'sd166886;
            13: v = 33'sd83443;
            14: v = 33'sd41722;
            15: v = 33'sd20861;
            16: v = 33'sd10430;
            17: v = 33'sd5215;
            18: v = 33'sd2608;
            19: v = 33'sd1304;
            20: v = 33'sd652;
            21: v = 33'sd326;
            22: v = 33'sd163;
            23: v = 33'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### hw/rtl/actf_cordic.sv
// pipelined rotation cordic, one stage per iteration, sine and cosine in q1.30
module actf_cordic import actf_pkg::*; (
    input  logic                   i_clk,
    input  logic [CORDIC_LAT-1:0]  i_en,
    input  logic [31:0]            i_ang,
    output logic signed [XY_W-1:0] o_cos,
    output logic signed [XY_W-1:0] o_sin
);

    localparam logic signed [Z_W-1:0] QUARTER = 33'sd1073741824;
    localparam logic signed [Z_W-1:0] HALF    = 33'sd2147483648;

    logic signed [XY_W-1:0] r_x   [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_y   [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  r_z   [0:CORDIC_STEPS];
    logic                   r_neg [0:CORDIC_STEPS];

    logic [31:0]           w_ang;
    logic signed [Z_W-1:0] w_z0;
    logic signed [Z_W-1:0] n_z0;
    logic                  n_neg0;

    assign w_ang = i_ang & ANG_MASK;
    assign w_z0  = Z_W'($signed(w_ang));

    // fold into the right half plane
    always_comb begin
        n_z0   = w_z0;
        n_neg0 = 1'b0;
        if (w_z0 > QUARTER) begin
            n_z0   = w_z0 - HALF;
            n_neg0 = 1'b1;
        end else if (w_z0 < -QUARTER) begin
            n_z0   = w_z0 + HALF;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]   <= CORDIC_GAIN;
            r_y[0]   <= '0;
            r_z[0]   <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en[i+1]) begin
                r_neg[i+1] <= r_neg[i];
                if (!r_z[i][Z_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - atan_turn(i);
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + atan_turn(i);
                end
            end
        end
    end

    assign o_cos = r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
    assign o_sin = r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];

endmodule

### hw/rtl/astigmatic_ctf_evaluator.sv
// astigmatic contrast transfer function evaluator, top level
// one request on the slave stream carries a spatial frequency and an azimuth;
// one result leaves on the master stream with -sin(phase) and the extremum count.
// the defocus registers, astigmatism angle, the two phase coefficients and the
// amplitude and phase plate shifts are loaded through the write port; the user
// must load them only while idle, which the block does not enforce. a request
// passes two 25-stage cordic pipelines (cosine of azimuth, sine of phase), the
// multiply and count stages between them and the output stage, 58 stages in all.
// throughput: one request per cycle unless stalled; each stage holds one request.
// a stalled receiver stops only the stages that are full: bubbles close up and
// the slave side keeps taking requests until the pipeline is packed.
// reset clears all valid bits and every configuration register to zero.
module astigmatic_ctf_evaluator import actf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [15:0] spatial_freq, [31:16] azimuth
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [15:0] ctf_value, [32:16] extrema_count
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [48:0] DIV1 = 49'(CNT_DIV);
    localparam logic [48:0] DIV2 = 49'(2 * CNT_DIV);

    logic [23:0]        r_dmin, r_dmax;
    logic [15:0]        r_ast;
    logic [31:0]        r_scale, r_coeff;
    logic [16:0]        r_amp;
    logic signed [18:0] r_extra;

    logic [NST-1:0] r_vld, n_vld, w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmin  <= '0;
            r_dmax  <= '0;
            r_ast   <= '0;
            r_scale <= '0;
            r_coeff <= '0;
            r_amp   <= '0;
            r_extra <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DMIN:  r_dmin  <= i_cfg_data[23:0];
                REG_DMAX:  r_dmax  <= i_cfg_data[23:0];
                REG_AST:   r_ast   <= i_cfg_data[15:0];
                REG_SCALE: r_scale <= i_cfg_data;
                REG_COEFF: r_coeff <= i_cfg_data;
                REG_AMP:   r_amp   <= i_cfg_data[16:0];
                REG_EXTRA: r_extra <= i_cfg_data[18:0];
                default: ;
            endcase
        end
    end

    // a stage may load when the receiver is ready or some stage at or after it is empty
    always_comb begin
        for (int k = 0; k < NST; k++) begin
            w_en[k] = i_m_tready | ~(&(r_vld | ((NST'(1) << k) - NST'(1))));
        end
    end

    assign o_s_tready = w_en[0];
    assign n_vld      = {r_vld[NST-2:0], i_s_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // cosine of twice the azimuth offset
    logic [15:0]            w_adiff;
    logic [31:0]            w_ang1;
    logic signed [XY_W-1:0] w_cos;

    assign w_adiff = i_s_tdata[31:16] - r_ast;
    assign w_ang1  = {w_adiff[14:0], 17'd0};

    actf_cordic u_cos (
        .i_clk (i_clk),
        .i_en  (w_en[CORDIC_LAT-1:0]),
        .i_ang (w_ang1),
        .o_cos (w_cos),
        .o_sin ()
    );

    logic signed [15:0] r_s_dly [0:CORDIC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s_dly[0] <= i_s_tdata[15:0];
        end
    end

    for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_sdly
        always_ff @(posedge i_clk) begin
            if (w_en[k]) begin
                r_s_dly[k] <= r_s_dly[k-1];
            end
        end
    end

    // defocus and frequency powers
    logic [24:0]        w_dsum;
    logic signed [24:0] w_ddiff;
    logic signed [31:0] w_s2sq;
    logic signed [58:0] r_pd;
    logic [30:0]        r_s2;

    assign w_dsum  = 25'(r_dmax) + 25'(r_dmin);
    assign w_ddiff = $signed({1'b0, r_dmax}) - $signed({1'b0, r_dmin});
    assign w_s2sq  = 32'(r_s_dly[CORDIC_LAT-1]) * 32'(r_s_dly[CORDIC_LAT-1]);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_A]) begin
            r_pd <= 59'(w_ddiff) * 59'(w_cos);
            r_s2 <= w_s2sq[30:0];
        end
    end

    logic signed [59:0] w_def35;
    logic signed [40:0] w_d16;
    logic               r_dneg_b;
    logic [39:0]        r_mag;
    logic [61:0]        r_p62;
    logic [60:0]        r_s4;

    assign w_def35 = $signed({5'd0, w_dsum, 30'd0}) + 60'(r_pd) + 60'sd262144;
    assign w_d16   = w_def35[59:19];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_B]) begin
            r_dneg_b <= w_d16[40];
            r_mag    <= 40'(w_d16[40] ? -w_d16 : w_d16);
            r_p62    <= 62'(r_s2) * 62'(r_scale);
            r_s4     <= 61'(r_s2) * 61'(r_s2);
        end
    end

    // partial products of the two wide terms
    logic [50:0] r_pp00, r_pp01, r_pp10, r_pp11;
    logic [62:0] r_qq0;
    logic [61:0] r_qq1;
    logic        r_dneg_c;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_C]) begin
            r_pp00   <= 51'(r_p62[30:0])  * 51'(r_mag[19:0]);
            r_pp01   <= 51'(r_p62[30:0])  * 51'(r_mag[39:20]);
            r_pp10   <= 51'(r_p62[61:31]) * 51'(r_mag[19:0]);
            r_pp11   <= 51'(r_p62[61:31]) * 51'(r_mag[39:20]);
            r_qq0    <= 63'(r_s4[30:0])  * 63'(r_coeff);
            r_qq1    <= 62'(r_s4[60:31]) * 62'(r_coeff);
            r_dneg_c <= r_dneg_b;
        end
    end

    logic [101:0] w_t1full;
    logic [93:0]  w_t2full;
    logic [39:0]  r_t1;
    logic [33:0]  r_t2;
    logic         r_dneg_d;

    assign w_t1full = 102'(r_pp00) + (102'(r_pp01) << 20) + (102'(r_pp10) << 31)
                    + (102'(r_pp11) << 51);
    assign w_t2full = 94'(r_qq0) + (94'(r_qq1) << 31);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_D]) begin
            r_t1     <= w_t1full[101:62];
            r_t2     <= w_t2full[93:60];
            r_dneg_d <= r_dneg_c;
        end
    end

    // phase in q.16 radians
    logic signed [41:0] w_t1s, r_phase;

    assign w_t1s = r_dneg_d ? -$signed({2'b0, r_t1}) : $signed({2'b0, r_t1});

    always_ff @(posedge i_clk) begin
        if (w_en[ST_E]) begin
            r_phase <= w_t1s - $signed({8'd0, r_t2}) + $signed({25'd0, r_amp})
                     + 42'(r_extra);
        end
    end

    // sine angle product and count numerator
    logic [47:0]        w_ph48;
    logic [53:0]        w_mlfull, w_mhfull;
    logic signed [55:0] w_num;
    logic [55:0]        w_nabs;
    logic [47:0]        r_ml;
    logic [23:0]        r_mh;
    logic               r_cneg_f, r_covf_f;
    logic [47:0]        r_cn_f;

    assign w_ph48   = 48'(r_phase);
    assign w_mlfull = 54'(w_ph48[23:0])  * 54'(INV2PI_Q16);
    assign w_mhfull = 54'(w_ph48[47:24]) * 54'(INV2PI_Q16);
    assign w_num    = (56'(r_phase) <<< 13) + 56'(PI_Q28);
    assign w_nabs   = w_num[55] ? 56'(-w_num) : 56'(w_num);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_F]) begin
            r_ml     <= w_mlfull[47:0];
            r_mh     <= w_mhfull[23:0];
            r_cneg_f <= w_num[55];
            r_covf_f <= |w_nabs[55:48];
            r_cn_f   <= w_nabs[47:0];
        end
    end

    logic [47:0] w_sfull;
    logic [31:0] r_sang;
    logic [49:0] r_m1;
    logic        r_cneg_g, r_covf_g;
    logic [47:0] r_cn_g;

    assign w_sfull = r_ml + {r_mh, 24'd0};

    always_ff @(posedge i_clk) begin
        if (w_en[ST_G]) begin
            r_sang   <= w_sfull[47:16];
            r_m1     <= 50'(r_cn_f[47:22]) * 50'(CNT_RECIP);
            r_cneg_g <= r_cneg_f;
            r_covf_g <= r_covf_f;
            r_cn_g   <= r_cn_f;
        end
    end

    // quotient estimate and correction
    logic [17:0] r_q0;
    logic [48:0] r_m2;
    logic        r_cneg_h, r_covf_h;
    logic [47:0] r_cn_h;

    always_ff @(posedge i_clk) begin
        if (w_en[ST_H]) begin
            r_q0     <= r_m1[49:32];
            r_m2     <= 49'(r_m1[49:32]) * 49'(CNT_DIV);
            r_cneg_h <= r_cneg_g;
            r_covf_h <= r_covf_g;
            r_cn_h   <= r_cn_g;
        end
    end

    logic [48:0]        w_rem;
    logic [18:0]        w_q;
    logic signed [16:0] n_cnt, r_cnt;

    assign w_rem = 49'(r_cn_h) - r_m2;
    assign w_q   = 19'(r_q0) + 19'(w_rem >= DIV1) + 19'(w_rem >= DIV2);

    always_comb begin
        if (!r_cneg_h) begin
            n_cnt = (r_covf_h || w_q > 19'd65535) ? 17'sd65535 : 17'(w_q);
        end else begin
            n_cnt = (r_covf_h || w_q > 19'd65536) ? 17'h10000 : -(17'(w_q));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_I]) begin
            r_cnt <= n_cnt;
        end
    end

    logic signed [16:0] r_cnt_dly [0:CNT_DLY-1];

    always_ff @(posedge i_clk) begin
        if (w_en[ST_I+1]) begin
            r_cnt_dly[0] <= r_cnt;
        end
    end

    for (genvar j = 1; j < CNT_DLY; j++) begin : g_cdly
        always_ff @(posedge i_clk) begin
            if (w_en[ST_I+1+j]) begin
                r_cnt_dly[j] <= r_cnt_dly[j-1];
            end
        end
    end

    // sine of phase
    logic signed [XY_W-1:0] w_sin;

    actf_cordic u_sin (
        .i_clk (i_clk),
        .i_en  (w_en[ST_C2 +: CORDIC_LAT]),
        .i_ang (r_sang),
        .o_cos (),
        .o_sin (w_sin)
    );

    // output register
    logic signed [XY_W-1:0] w_sr, w_sneg;
    logic signed [15:0]     n_ctf, r_ctf;
    logic signed [16:0]     r_cnt_out;

    assign w_sr   = (w_sin + 34'sd16384) >>> 15;
    assign w_sneg = -w_sr;

    always_comb begin
        if (w_sneg > 34'sd32767) begin
            n_ctf = 16'sd32767;
        end else if (w_sneg < -34'sd32767) begin
            n_ctf = -16'sd32767;
        end else begin
            n_ctf = 16'(w_sneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_OUT]) begin
            r_ctf     <= n_ctf;
            r_cnt_out <= r_cnt_dly[CNT_DLY-1];
        end
    end

    assign o_m_tvalid = r_vld[ST_OUT];
    assign o_m_tdata  = {7'd0, r_cnt_out, r_ctf};

`ifndef SYNTHESIS
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");
    a_en_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en[ST_OUT] |-> o_s_tready)
        else $error("output advances while input is blocked");
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT] && r_vld[ST_OUT-1] && !i_m_tready) |-> !w_en[ST_OUT-1])
        else $error("full stage overwritten under stall");
    a_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_OUT-1] && w_en[ST_OUT-1]) |=> r_vld[ST_OUT])
        else $error("request lost before output stage");
    a_ctf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:0] != 16'h8000))
        else $error("ctf value outside clamp");
`endif

endmodule
